// File: rtl/fcs_pkg.sv
package fcs_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int AXES          = 3;
  localparam int WORD_W        = 32;
  localparam int DT_W          = 16;
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int SUM_W         = WORD_W + $clog2(MAX_PARTICLES);
  localparam int STEP_W        = $clog2(SUM_W);
  localparam int DIFF_W        = WORD_W + 1;
  localparam int PROD_W        = DIFF_W + DT_W + 1;
  localparam int PULL_W        = PROD_W - DT_W;
  localparam int RES_W         = PULL_W + 1;

  localparam logic OP_FRAME    = 1'b0;
  localparam logic OP_PARTICLE = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DT_W-1:0]   dt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SAT,
    S_DIV
  } state_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic sat;
    logic div_start;
    logic center_home;
    logic center_div;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_free;
    logic div_done;
  } sts_t;

endpackage

// File: rtl/fcs_div.sv
module fcs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  fcs_pkg::cnt_t       divisor,
  input  fcs_pkg::sum_t       dividend [fcs_pkg::AXES],
  output logic                done,
  output fcs_pkg::word_t      quotient [fcs_pkg::AXES]
);

  logic                        busy_r;
  logic                        done_r;
  logic [fcs_pkg::STEP_W-1:0]  step_r;
  fcs_pkg::cnt_t               d_r;
  fcs_pkg::cnt_t               rem_r [fcs_pkg::AXES];
  fcs_pkg::sum_t               quo_r [fcs_pkg::AXES];
  logic [fcs_pkg::AXES-1:0]    neg_r;

  logic [fcs_pkg::CNT_W:0]     sh    [fcs_pkg::AXES];
  logic [fcs_pkg::CNT_W:0]     trial [fcs_pkg::AXES];
  logic [fcs_pkg::AXES-1:0]    ge;
  fcs_pkg::cnt_t               rem_nxt [fcs_pkg::AXES];
  fcs_pkg::word_t              q_low   [fcs_pkg::AXES];

  // one restoring step per cycle, three lanes share the divisor
  always_comb begin
    for (int i = 0; i < fcs_pkg::AXES; i++) begin
      sh[i]      = {rem_r[i], quo_r[i][fcs_pkg::SUM_W-1]};
      trial[i]   = sh[i] - {1'b0, d_r};
      ge[i]      = sh[i] >= {1'b0, d_r};
      rem_nxt[i] = ge[i] ? trial[i][fcs_pkg::CNT_W-1:0] : sh[i][fcs_pkg::CNT_W-1:0];
      q_low[i]   = quo_r[i][fcs_pkg::WORD_W-1:0];
      quotient[i] = neg_r[i] ? fcs_pkg::word_t'(-q_low[i]) : q_low[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == fcs_pkg::STEP_W'(fcs_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= divisor;
      for (int i = 0; i < fcs_pkg::AXES; i++) begin
        rem_r[i] <= '0;
        neg_r[i] <= dividend[i][fcs_pkg::SUM_W-1];
        quo_r[i] <= dividend[i][fcs_pkg::SUM_W-1] ? fcs_pkg::sum_t'(-dividend[i])
                                                   : dividend[i];
      end
    end else if (busy_r) begin
      for (int i = 0; i < fcs_pkg::AXES; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= {quo_r[i][fcs_pkg::SUM_W-2:0], ge[i]};
      end
    end
  end

  assign done = done_r;

endmodule

// File: rtl/fcs_dp.sv
module fcs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  fcs_pkg::cmd_t      cmd,
  output fcs_pkg::sts_t      sts,
  input  fcs_pkg::word_t     pos  [fcs_pkg::AXES],
  input  fcs_pkg::word_t     dir  [fcs_pkg::AXES],
  input  fcs_pkg::word_t     home [fcs_pkg::AXES],
  input  fcs_pkg::dt_t       delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output fcs_pkg::word_t     new_dir [fcs_pkg::AXES]
);

  fcs_pkg::word_t              pos_r    [fcs_pkg::AXES];
  fcs_pkg::word_t              dir_r    [fcs_pkg::AXES];
  fcs_pkg::dt_t                dt_r;
  fcs_pkg::word_t              center_r [fcs_pkg::AXES];
  fcs_pkg::sum_t               sum_r    [fcs_pkg::AXES];
  fcs_pkg::cnt_t               count_r;
  logic signed [fcs_pkg::PROD_W-1:0] prod_r [fcs_pkg::AXES];
  logic                        out_valid_r;
  fcs_pkg::word_t              out_r    [fcs_pkg::AXES];

  logic [fcs_pkg::DIFF_W-1:0]  diff     [fcs_pkg::AXES];
  logic [fcs_pkg::PULL_W-1:0]  pull     [fcs_pkg::AXES];
  logic [fcs_pkg::RES_W-1:0]   res      [fcs_pkg::AXES];
  logic [fcs_pkg::RES_W-fcs_pkg::WORD_W:0] top_bits [fcs_pkg::AXES];
  fcs_pkg::word_t              sat_val  [fcs_pkg::AXES];
  fcs_pkg::word_t              quotient [fcs_pkg::AXES];
  logic                        div_done;
  logic                        not_full;

  fcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (count_r),
    .dividend (sum_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign not_full = count_r < fcs_pkg::CNT_W'(fcs_pkg::MAX_PARTICLES);

  always_comb begin
    for (int i = 0; i < fcs_pkg::AXES; i++) begin
      diff[i] = {center_r[i][fcs_pkg::WORD_W-1], center_r[i]}
              - {pos_r[i][fcs_pkg::WORD_W-1], pos_r[i]};
      // arithmetic shift of the product floors toward minus infinity
      pull[i] = prod_r[i][fcs_pkg::PROD_W-1:fcs_pkg::DT_W];
      res[i]  = {{(fcs_pkg::RES_W-fcs_pkg::WORD_W){dir_r[i][fcs_pkg::WORD_W-1]}}, dir_r[i]}
              + {pull[i][fcs_pkg::PULL_W-1], pull[i]};
      top_bits[i] = res[i][fcs_pkg::RES_W-1:fcs_pkg::WORD_W-1];
      if ((&top_bits[i]) || !(|top_bits[i])) begin
        sat_val[i] = res[i][fcs_pkg::WORD_W-1:0];
      end else if (res[i][fcs_pkg::RES_W-1]) begin
        sat_val[i] = {1'b1, {(fcs_pkg::WORD_W-1){1'b0}}};
      end else begin
        sat_val[i] = {1'b0, {(fcs_pkg::WORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r <= pos;
      dir_r <= dir;
      dt_r  <= delta_time;
    end
    for (int i = 0; i < fcs_pkg::AXES; i++) begin
      prod_r[i] <= $signed(diff[i]) * $signed({1'b0, dt_r});
    end
    if (cmd.sat) begin
      out_r <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < fcs_pkg::AXES; i++) begin
        sum_r[i]    <= '0;
        center_r[i] <= '0;
      end
    end else begin
      if (cmd.sat) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.center_home) begin
        center_r <= home;
      end else if (cmd.center_div) begin
        center_r <= quotient;
      end
      if (cmd.clr) begin
        count_r <= '0;
        for (int i = 0; i < fcs_pkg::AXES; i++) begin
          sum_r[i] <= '0;
        end
      end else if (cmd.acc && not_full) begin
        count_r <= count_r + 1'b1;
        for (int i = 0; i < fcs_pkg::AXES; i++) begin
          sum_r[i] <= sum_r[i]
                    + {{(fcs_pkg::SUM_W-fcs_pkg::WORD_W){pos_r[i][fcs_pkg::WORD_W-1]}},
                       pos_r[i]};
        end
      end
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.div_done   = div_done;
  assign out_valid      = out_valid_r;
  assign new_dir        = out_r;

endmodule

// File: rtl/fcs_ctrl.sv
module fcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_operation,
  output logic             in_stall,
  input  fcs_pkg::sts_t    sts,
  output fcs_pkg::cmd_t    cmd
);

  fcs_pkg::state_t state_r;
  fcs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_operation == fcs_pkg::OP_PARTICLE) begin
            state_nxt = fcs_pkg::S_MUL;
          end else if (!sts.count_zero) begin
            state_nxt = fcs_pkg::S_DIV;
          end
        end
      end
      fcs_pkg::S_MUL: state_nxt = fcs_pkg::S_SAT;
      fcs_pkg::S_SAT: begin
        if (sts.out_free) begin
          state_nxt = fcs_pkg::S_IDLE;
        end
      end
      fcs_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = fcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = fcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      fcs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && in_operation == fcs_pkg::OP_FRAME) begin
          if (sts.count_zero) begin
            cmd.center_home = 1'b1;
            cmd.clr         = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
      end
      fcs_pkg::S_MUL: cmd.acc = 1'b1;
      fcs_pkg::S_SAT: cmd.sat = sts.out_free;
      fcs_pkg::S_DIV: begin
        cmd.center_div = sts.div_done;
        cmd.clr        = sts.div_done;
      end
      default: ;
    endcase
  end

  a_particle_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcs_pkg::S_IDLE && in_valid && in_operation == fcs_pkg::OP_PARTICLE)
      |=> state_r == fcs_pkg::S_MUL)
    else $error("particle transaction did not enter multiply");

  a_mul_to_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcs_pkg::S_MUL |=> state_r == fcs_pkg::S_SAT)
    else $error("multiply not followed by result write");

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == fcs_pkg::S_DIV && !sts.div_done))
    else $error("divider start did not begin a division");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == fcs_pkg::S_DIV)
    else $error("divider finished outside a division");

endmodule

// File: rtl/flock_centering_step.sv
// Flock cohesion step. A frame-start transaction latches the center used by every particle of
// the frame (mean of the previous frame's positions, or the home position if that frame saw no
// particles) and gives no result. A particle transaction is registered, then takes one 33x17
// multiply per axis, then an add and saturate into the output register, which lets the next
// transaction in while a result waits; the saturate step stalls while an earlier result is held.
// A frame start after an empty frame loads the home position directly; otherwise the bit-serial
// divider forms all three means in parallel, one quotient bit per cycle.
module flock_centering_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic signed [31:0]     in_pos_x,
  input  logic signed [31:0]     in_pos_y,
  input  logic signed [31:0]     in_pos_z,
  input  logic signed [31:0]     in_dir_x,
  input  logic signed [31:0]     in_dir_y,
  input  logic signed [31:0]     in_dir_z,
  input  logic [15:0]            in_delta_time,
  input  logic signed [31:0]     in_home_x,
  input  logic signed [31:0]     in_home_y,
  input  logic signed [31:0]     in_home_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_new_dir_x,
  output logic signed [31:0]     out_new_dir_y,
  output logic signed [31:0]     out_new_dir_z
);

  fcs_pkg::cmd_t  cmd;
  fcs_pkg::sts_t  sts;
  fcs_pkg::word_t pos_w  [fcs_pkg::AXES];
  fcs_pkg::word_t dir_w  [fcs_pkg::AXES];
  fcs_pkg::word_t home_w [fcs_pkg::AXES];
  fcs_pkg::word_t res_w  [fcs_pkg::AXES];

  assign pos_w[0]  = in_pos_x;
  assign pos_w[1]  = in_pos_y;
  assign pos_w[2]  = in_pos_z;
  assign dir_w[0]  = in_dir_x;
  assign dir_w[1]  = in_dir_y;
  assign dir_w[2]  = in_dir_z;
  assign home_w[0] = in_home_x;
  assign home_w[1] = in_home_y;
  assign home_w[2] = in_home_z;

  fcs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  fcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pos        (pos_w),
    .dir        (dir_w),
    .home       (home_w),
    .delta_time (in_delta_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .new_dir    (res_w)
  );

  assign out_new_dir_x = res_w[0];
  assign out_new_dir_y = res_w[1];
  assign out_new_dir_z = res_w[2];

endmodule
